// ===== rtl/starfield_point_rotate_clip_defines.svh =====
// Assertion macros shared by the star field point rotate and clip block.
`ifndef STARFIELD_POINT_ROTATE_CLIP_DEFINES_SVH
`define STARFIELD_POINT_ROTATE_CLIP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define SFPRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define SFPRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFPRC_ASSERT(lbl, clk, rstn, prop, msg)
`define SFPRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/sfprc_pkg.sv =====
// Shared types, constants and width helpers of the star field point rotate and clip block.
package sfprc_pkg;

  localparam int unsigned OffW     = 16;
  localparam int unsigned FieldW   = 15;
  localparam int unsigned TrigW    = 16;
  localparam int unsigned StretchW = 9;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned PixW     = 16;
  localparam int unsigned PixXW    = 11;
  localparam int unsigned PixYW    = 8;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned LimW     = 19;

  // Field geometry in whole pixels.
  localparam int unsigned WrapX = 400;
  localparam int unsigned SpanX = 480;
  localparam int unsigned CtrX  = 160;
  localparam int unsigned WrapY = 300;
  localparam int unsigned SpanY = 360;
  localparam int unsigned CtrY  = 120;
  localparam int unsigned ScrW  = 320;
  localparam int unsigned ScrH  = 240;

  typedef enum logic [2:0] {
    REG_FIELD_X   = 3'd0,
    REG_FIELD_Y   = 3'd1,
    REG_COS_ROLL  = 3'd2,
    REG_SIN_ROLL  = 3'd3,
    REG_X_STRETCH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        [FieldW-1:0]   field_x;
    logic        [FieldW-1:0]   field_y;
    logic signed [TrigW-1:0]    cos_roll;
    logic signed [TrigW-1:0]    sin_roll;
    logic        [StretchW-1:0] x_stretch;
  } cfg_t;

  // Stretched x, Q.(2F), with room for both wrap subtractions.
  function automatic int bx_w(input int f);
    return f + 24;
  endfunction

  // Field y, Q.F, after wrap and recentering.
  function automatic int by_w(input int f);
    return f + 14;
  endfunction

  // Stretch-derived x constants (threshold and subtrahends), Q.(2F).
  function automatic int xc_w(input int f);
    return f + 20;
  endfunction

  // Rotation accumulator, Q.(T+2F).
  function automatic int acc_w(input int f, input int t);
    int a;
    a = f + 38;
    if (2 * f + 28 > a) a = 2 * f + 28;
    if (t + 2 * f + 13 > a) a = t + 2 * f + 13;
    return a + 3;
  endfunction

endpackage

// ===== rtl/sfprc_cfg.sv =====
// Configuration register file with the stretch-derived constants.
module sfprc_cfg import sfprc_pkg::*; #(
  parameter int FRAC_BITS = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [AddrW-1:0]               paddr,
  input  logic [DataW-1:0]               pwdata,
  output logic [DataW-1:0]               prdata,
  output logic                           pready,
  output cfg_t                           cfg,
  output logic [xc_w(FRAC_BITS)-1:0]     wrap_thr,
  output logic [xc_w(FRAC_BITS)-1:0]     sub_hi,
  output logic [xc_w(FRAC_BITS)-1:0]     sub_lo,
  output logic [LimW-1:0]                clip_lim
);

  localparam int CW = xc_w(FRAC_BITS);

  cfg_t            cfg_r;
  logic [CW-1:0]   wrap_thr_r, sub_hi_r, sub_lo_r;
  logic [LimW-1:0] clip_lim_r;
  logic            wr_en;
  reg_idx_t        idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_x   <= '0;
      cfg_r.field_y   <= '0;
      cfg_r.cos_roll  <= 16'sh4000;
      cfg_r.sin_roll  <= '0;
      cfg_r.x_stretch <= 9'd128;
    end else if (wr_en) begin
      case (idx)
        REG_FIELD_X:   cfg_r.field_x   <= pwdata[FieldW-1:0];
        REG_FIELD_Y:   cfg_r.field_y   <= pwdata[FieldW-1:0];
        REG_COS_ROLL:  cfg_r.cos_roll  <= $signed(pwdata[TrigW-1:0]);
        REG_SIN_ROLL:  cfg_r.sin_roll  <= $signed(pwdata[TrigW-1:0]);
        REG_X_STRETCH: cfg_r.x_stretch <= pwdata[StretchW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIELD_X:   prdata = {{(DataW-FieldW){1'b0}}, cfg_r.field_x};
      REG_FIELD_Y:   prdata = {{(DataW-FieldW){1'b0}}, cfg_r.field_y};
      REG_COS_ROLL:  prdata = {{(DataW-TrigW){cfg_r.cos_roll[TrigW-1]}}, cfg_r.cos_roll};
      REG_SIN_ROLL:  prdata = {{(DataW-TrigW){cfg_r.sin_roll[TrigW-1]}}, cfg_r.sin_roll};
      REG_X_STRETCH: prdata = {{(DataW-StretchW){1'b0}}, cfg_r.x_stretch};
      default:       prdata = '0;
    endcase
  end

  // Constant multiples of the stretch, refreshed every cycle so the
  // products stay off the datapath.
  always_ff @(posedge clk) begin
    wrap_thr_r <= (CW'(cfg_r.x_stretch) * CW'(WrapX)) << FRAC_BITS;
    sub_hi_r   <= (CW'(cfg_r.x_stretch) * CW'(SpanX + CtrX)) << FRAC_BITS;
    sub_lo_r   <= (CW'(cfg_r.x_stretch) * CW'(CtrX)) << FRAC_BITS;
    clip_lim_r <= LimW'(cfg_r.x_stretch) * LimW'(ScrW);
  end

  assign cfg      = cfg_r;
  assign wrap_thr = wrap_thr_r;
  assign sub_hi   = sub_hi_r;
  assign sub_lo   = sub_lo_r;
  assign clip_lim = clip_lim_r;

endmodule

// ===== rtl/sfprc_wrap.sv =====
// Field offset, horizontal stretch and wrap of one star (two pipeline stages).
module sfprc_wrap import sfprc_pkg::*; #(
  parameter int FRAC_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic signed [OffW-1:0]            offset_x,
  input  logic signed [OffW-1:0]            offset_y,
  input  logic        [ColorW-1:0]          color_in,
  input  cfg_t                              cfg,
  input  logic        [xc_w(FRAC_BITS)-1:0] wrap_thr,
  input  logic        [xc_w(FRAC_BITS)-1:0] sub_hi,
  input  logic        [xc_w(FRAC_BITS)-1:0] sub_lo,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic signed [bx_w(FRAC_BITS)-1:0] bx,
  output logic signed [by_w(FRAC_BITS)-1:0] by,
  output logic        [ColorW-1:0]          color_out
);

  localparam int BX_W = bx_w(FRAC_BITS);
  localparam int BY_W = by_w(FRAC_BITS);
  localparam int CW   = xc_w(FRAC_BITS);
  localparam logic signed [BY_W-1:0] YTHR   = BY_W'(WrapY << FRAC_BITS);
  localparam logic signed [BY_W-1:0] YSUBHI = BY_W'((SpanY + CtrY) << FRAC_BITS);
  localparam logic signed [BY_W-1:0] YSUBLO = BY_W'(CtrY << FRAC_BITS);

  logic                   v1_r, v2_r, en1, en2;
  logic signed [16:0]     sx, sy;
  logic signed [26:0]     bx_prod;
  logic signed [BY_W-1:0] sy_ext;
  logic signed [BX_W-1:0] bx1_r, bx1_nxt, bx2_r, bx2_nxt;
  logic signed [BY_W-1:0] by1_r, by1_nxt, by2_r;
  logic [ColorW-1:0]      col1_r, col2_r;
  logic signed [BX_W-1:0] thr_s, hi_s, lo_s;

  assign en2     = !v2_r || m_ready;
  assign en1     = !v1_r || en2;
  assign s_ready = en1;

  // Stage 1: add the scroll, stretch x, wrap and recenter y.
  assign sx      = $signed({offset_x[OffW-1], offset_x}) + $signed({2'b00, cfg.field_x});
  assign sy      = $signed({offset_y[OffW-1], offset_y}) + $signed({2'b00, cfg.field_y});
  assign bx_prod = sx * $signed({1'b0, cfg.x_stretch});
  assign bx1_nxt = {{(BX_W-27){bx_prod[26]}}, bx_prod};
  assign sy_ext  = {{(BY_W-17){sy[16]}}, sy};
  assign by1_nxt = (sy_ext >= YTHR) ? (sy_ext - YSUBHI) : (sy_ext - YSUBLO);

  // Stage 2: wrap and recenter the stretched x.
  assign thr_s   = $signed({{(BX_W-CW){1'b0}}, wrap_thr});
  assign hi_s    = $signed({{(BX_W-CW){1'b0}}, sub_hi});
  assign lo_s    = $signed({{(BX_W-CW){1'b0}}, sub_lo});
  assign bx2_nxt = (bx1_r >= thr_s) ? (bx1_r - hi_s) : (bx1_r - lo_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= s_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      bx1_r  <= bx1_nxt;
      by1_r  <= by1_nxt;
      col1_r <= color_in;
    end
    if (en2) begin
      bx2_r  <= bx2_nxt;
      by2_r  <= by1_r;
      col2_r <= col1_r;
    end
  end

  assign m_valid   = v2_r;
  assign bx        = bx2_r;
  assign by        = by2_r;
  assign color_out = col2_r;

endmodule

// ===== rtl/sfprc_rot.sv =====
// Roll rotation: four products, then the two rotated sums with the centre (two stages).
module sfprc_rot import sfprc_pkg::*; #(
  parameter int FRAC_BITS      = 6,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              s_valid,
  output logic                                              s_ready,
  input  logic signed [bx_w(FRAC_BITS)-1:0]                 bx,
  input  logic signed [by_w(FRAC_BITS)-1:0]                 by,
  input  logic        [ColorW-1:0]                          color_in,
  input  cfg_t                                              cfg,
  output logic                                              m_valid,
  input  logic                                              m_ready,
  output logic signed [acc_w(FRAC_BITS, TRIG_FRAC_BITS)-1:0] ax,
  output logic signed [acc_w(FRAC_BITS, TRIG_FRAC_BITS)-1:0] ay,
  output logic        [ColorW-1:0]                          color_out
);

  localparam int BX_W  = bx_w(FRAC_BITS);
  localparam int BY_W  = by_w(FRAC_BITS);
  localparam int ACC_W = acc_w(FRAC_BITS, TRIG_FRAC_BITS);
  localparam int PX_W  = TrigW + BX_W;
  localparam int PY_W  = TrigW + BY_W;
  localparam int SH    = TRIG_FRAC_BITS + 2 * FRAC_BITS;
  localparam logic signed [ACC_W-1:0] CTR_AX = ACC_W'(longint'(CtrX) << SH);
  localparam logic signed [ACC_W-1:0] CTR_AY = ACC_W'(longint'(CtrY) << SH);

  logic                    v3_r, v4_r, en3, en4;
  logic signed [PX_W-1:0]  p_cx_r, p_sx_r;
  logic signed [PY_W-1:0]  p_cy_r, p_sy_r;
  logic [ColorW-1:0]       col3_r, col4_r;
  logic signed [ACC_W-1:0] cx_e, sx_e, cy_e, sy_e;
  logic signed [ACC_W-1:0] ax_nxt, ay_nxt, ax_r, ay_r;

  assign en4     = !v4_r || m_ready;
  assign en3     = !v3_r || en4;
  assign s_ready = en3;

  // Stage 4 operands: y terms carry one more Q.F factor to line up with x.
  assign cx_e = $signed({{(ACC_W-PX_W){p_cx_r[PX_W-1]}}, p_cx_r});
  assign sx_e = $signed({{(ACC_W-PX_W){p_sx_r[PX_W-1]}}, p_sx_r});
  assign cy_e = $signed({{(ACC_W-PY_W-FRAC_BITS){p_cy_r[PY_W-1]}}, p_cy_r,
                         {FRAC_BITS{1'b0}}});
  assign sy_e = $signed({{(ACC_W-PY_W-FRAC_BITS){p_sy_r[PY_W-1]}}, p_sy_r,
                         {FRAC_BITS{1'b0}}});

  assign ax_nxt = cx_e + sy_e + CTR_AX;
  assign ay_nxt = cy_e - sx_e + CTR_AY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) v3_r <= s_valid;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      p_cx_r <= cfg.cos_roll * bx;
      p_sx_r <= cfg.sin_roll * bx;
      p_cy_r <= cfg.cos_roll * by;
      p_sy_r <= cfg.sin_roll * by;
      col3_r <= color_in;
    end
    if (en4) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      col4_r <= col3_r;
    end
  end

  assign m_valid   = v4_r;
  assign ax        = ax_r;
  assign ay        = ay_r;
  assign color_out = col4_r;

endmodule

// ===== rtl/sfprc_clip.sv =====
// Truncation to a 16-bit pixel, screen test and output register.
module sfprc_clip import sfprc_pkg::*; #(
  parameter int FRAC_BITS      = 6,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              s_valid,
  output logic                                              s_ready,
  input  logic signed [acc_w(FRAC_BITS, TRIG_FRAC_BITS)-1:0] ax,
  input  logic signed [acc_w(FRAC_BITS, TRIG_FRAC_BITS)-1:0] ay,
  input  logic        [ColorW-1:0]                          color_in,
  input  logic        [LimW-1:0]                            clip_lim,
  output logic                                              m_valid,
  input  logic                                              m_ready,
  output logic        [PixXW-1:0]                           pixel_x,
  output logic        [PixYW-1:0]                           pixel_y,
  output logic        [ColorW-1:0]                          pixel_color
);

  localparam int ACC_W = acc_w(FRAC_BITS, TRIG_FRAC_BITS);
  localparam int SH    = TRIG_FRAC_BITS + 2 * FRAC_BITS;
  localparam int CMP_W = FRAC_BITS + 16;

  logic              v_r, en, corr_x, corr_y, visible;
  logic [PixW-1:0]   vx, vy;
  logic [CMP_W-1:0]  vx_scaled, lim_ext;
  logic [PixXW-1:0]  px_r;
  logic [PixYW-1:0]  py_r;
  logic [ColorW-1:0] col_r;

  assign en      = !v_r || m_ready;
  assign s_ready = en;

  // Arithmetic shift rounds toward minus infinity; a negative sum with
  // fraction bits left needs one added to round toward zero.
  assign corr_x = ax[ACC_W-1] & (|ax[SH-1:0]);
  assign corr_y = ay[ACC_W-1] & (|ay[SH-1:0]);
  assign vx     = ax[SH+PixW-1:SH] + {{(PixW-1){1'b0}}, corr_x};
  assign vy     = ay[SH+PixW-1:SH] + {{(PixW-1){1'b0}}, corr_y};

  assign vx_scaled = {1'b0, vx[PixW-2:0], {FRAC_BITS{1'b0}}};
  assign lim_ext   = {{(CMP_W-LimW){1'b0}}, clip_lim};
  assign visible   = !vx[PixW-1] && (vx_scaled < lim_ext) &&
                     !vy[PixW-1] && (vy != '0) && (vy[PixW-2:0] < (PixW-1)'(ScrH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= s_valid && visible;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= vx[PixXW-1:0];
      py_r  <= vy[PixYW-1:0];
      col_r <= color_in;
    end
  end

  assign m_valid     = v_r;
  assign pixel_x     = px_r;
  assign pixel_y     = py_r;
  assign pixel_color = col_r;

endmodule

// ===== rtl/starfield_point_rotate_clip.sv =====
// Top level of the star field point rotate and clip pipeline.
//
//  Channel | Direction | Transfer when            | Payload
//  --------+-----------+--------------------------+---------------------------------------
//  in_     | sink      | in_tvalid & in_tready    | offset_x, offset_y, star_color
//  out_    | source    | out_tvalid & out_tready  | pixel_x, pixel_y, pixel_color
//  APB     | slave     | psel & penable & pwrite  | field_x, field_y, cos_roll, sin_roll,
//          |           |                          | x_stretch at byte addresses 0..16
//
// One star enters per cycle while the pipeline has room, and its pixel leaves
// after passing the five register stages: scroll add and stretch multiply,
// x wrap, four rotation multipliers, rotated sums, and truncation with the
// screen test in the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. There is no clearing pass.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles close up and the input keeps taking transfers while a finished pixel
// waits. Stars that fall off the screen leave no output transfer.
`include "starfield_point_rotate_clip_defines.svh"
module starfield_point_rotate_clip import sfprc_pkg::*; #(
  parameter int FRAC_BITS      = 6,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  // APB configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  // Star input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  // [15:0] offset_x, [31:16] offset_y, [63:32] star_color
  input  logic [InDataW-1:0]  in_tdata,
  // Pixel output stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  // [10:0] pixel_x, [18:11] pixel_y, [50:19] pixel_color, [55:51] zero
  output logic [OutDataW-1:0] out_tdata
);

  localparam int BX_W  = bx_w(FRAC_BITS);
  localparam int BY_W  = by_w(FRAC_BITS);
  localparam int CW    = xc_w(FRAC_BITS);
  localparam int ACC_W = acc_w(FRAC_BITS, TRIG_FRAC_BITS);

  cfg_t                   cfg;
  logic [CW-1:0]          wrap_thr, sub_hi, sub_lo;
  logic [LimW-1:0]        clip_lim;

  logic                   wrap_valid, wrap_ready;
  logic signed [BX_W-1:0] bx;
  logic signed [BY_W-1:0] by;
  logic [ColorW-1:0]      wrap_color;

  logic                   rot_valid, rot_ready;
  logic signed [ACC_W-1:0] ax, ay;
  logic [ColorW-1:0]      rot_color;

  logic [PixXW-1:0]       pixel_x;
  logic [PixYW-1:0]       pixel_y;
  logic [ColorW-1:0]      pixel_color;

  sfprc_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .wrap_thr (wrap_thr),
    .sub_hi   (sub_hi),
    .sub_lo   (sub_lo),
    .clip_lim (clip_lim)
  );

  sfprc_wrap #(
    .FRAC_BITS (FRAC_BITS)
  ) u_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (in_tvalid),
    .s_ready   (in_tready),
    .offset_x  ($signed(in_tdata[15:0])),
    .offset_y  ($signed(in_tdata[31:16])),
    .color_in  (in_tdata[63:32]),
    .cfg       (cfg),
    .wrap_thr  (wrap_thr),
    .sub_hi    (sub_hi),
    .sub_lo    (sub_lo),
    .m_valid   (wrap_valid),
    .m_ready   (wrap_ready),
    .bx        (bx),
    .by        (by),
    .color_out (wrap_color)
  );

  sfprc_rot #(
    .FRAC_BITS      (FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (wrap_valid),
    .s_ready   (wrap_ready),
    .bx        (bx),
    .by        (by),
    .color_in  (wrap_color),
    .cfg       (cfg),
    .m_valid   (rot_valid),
    .m_ready   (rot_ready),
    .ax        (ax),
    .ay        (ay),
    .color_out (rot_color)
  );

  sfprc_clip #(
    .FRAC_BITS      (FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (rot_valid),
    .s_ready     (rot_ready),
    .ax          (ax),
    .ay          (ay),
    .color_in    (rot_color),
    .clip_lim    (clip_lim),
    .m_valid     (out_tvalid),
    .m_ready     (out_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color)
  );

  assign out_tdata = {{(OutDataW-PixXW-PixYW-ColorW){1'b0}}, pixel_color, pixel_y, pixel_x};

  // The input only stalls when every stage is full and the output is blocked.
  `SFPRC_ASSERT(a_stall_only_when_full, clk, rst_n, !in_tready |-> (out_tvalid && !out_tready), "input stalled while the pipeline had room")
  // A delivered pixel always lies strictly inside the screen rows.
  `SFPRC_ASSERT(a_row_on_screen, clk, rst_n, out_tvalid |-> (pixel_y != '0 && pixel_y < PixYW'(ScrH)), "pixel row outside the screen")
  // Reset empties the output register.
  `SFPRC_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

// ===== test/starfield_point_rotate_clip_tb.sv =====
// Self-checking testbench for the star field point rotate and clip pipeline.
module starfield_point_rotate_clip_tb;
  import sfprc_pkg::*;

  // Fixed-point formats of the block as instantiated.
  localparam int FracBits     = 6;
  localparam int TrigFracBits = 14;
  localparam longint OneF     = longint'(1) << FracBits;
  localparam longint OneRot   = longint'(1) << (TrigFracBits + 2 * FracBits);

  // The pipeline is five stages deep; this pause covers stars that are still
  // in flight but will never produce a pixel.
  localparam int LatencyPause = 12;
  localparam int DrainLimit   = 20000;
  localparam int HoldCycles   = 80;
  localparam int MaxShown     = 10;
  localparam int NumRegs      = 5;
  localparam int LastRegSlot  = (1 << AddrW) / 4 - 1;
  localparam int NumRows      = 16;
  localparam int NumPhases    = 9;

  typedef struct packed {
    logic [PixXW-1:0]  px;
    logic [PixYW-1:0]  py;
    logic [ColorW-1:0] color;
  } pixel_t;

  // One directed star. Where typed is set, the expected outcome is written
  // out by hand for the reset configuration; otherwise it comes from the
  // predictor.
  typedef struct {
    logic [OffW-1:0]   ox;
    logic [OffW-1:0]   oy;
    logic [ColorW-1:0] color;
    bit                typed;
    bit                hit;
    int                px;
    int                py;
  } star_row_t;

  // One configuration phase. When rnd is set the register values are drawn
  // at random; the flags shape idling and back-pressure for the phase.
  typedef struct {
    int fx;
    int fy;
    int cs;
    int sn;
    int st;
    int items;
    bit rnd;
    bit rx_steady;
    bit tx_steady;
    bit long_hold;
    bit mid_pause;
  } phase_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_tvalid;
  logic                in_tready;
  // [15:0] offset_x, [31:16] offset_y, [63:32] star_color
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  // [10:0] pixel_x, [18:11] pixel_y, [50:19] pixel_color, [55:51] zero
  logic [OutDataW-1:0] out_tdata;

  // Shadow of the register file, kept in step with every write.
  cfg_t   shadow_cfg;
  // Pixels that accepted stars are due to produce, oldest first.
  pixel_t pending_pixels[$];
  int     err_count;
  // Idling controls shared between the stimulus and the result sink.
  bit     rx_steady;
  bit     tx_steady;
  bit     hold_req;

  // Directed stars under the reset configuration (no scroll, no roll,
  // stretch 2.0). There, column = 2*x - 160 and row = y, both truncated
  // toward zero.
  star_row_t star_rows [0:NumRows-1] = '{
    // Left edge of the screen: column 0, row 60.
    '{16'd5120,  16'd3840,  32'h0000_0000, 1'b1, 1'b1, 0,   60},
    // Bottom right corner: last visible column and row.
    '{16'd25599, 16'd15359, 32'hFFFF_FFFF, 1'b1, 1'b1, 639, 239},
    // Column -0.03 truncates toward zero to 0; row 1 is the first visible.
    '{16'd5119,  16'd64,    32'hA5A5_A5A5, 1'b1, 1'b1, 0,   1},
    // Column exactly -1 is off screen.
    '{16'd5088,  16'd3840,  32'h5A5A_5A5A, 1'b1, 1'b0, 0,   0},
    // Largest nominal x offset wraps around to the far left.
    '{16'd25600, 16'd3840,  32'h1234_5678, 1'b1, 1'b0, 0,   0},
    // Smallest nominal offsets in x and in y.
    '{16'hEC00,  16'd3840,  32'h8765_4321, 1'b1, 1'b0, 0,   0},
    '{16'd5120,  16'hF100,  32'h0F0F_0F0F, 1'b1, 1'b0, 0,   0},
    // Largest nominal y offset wraps to row -60, above the screen.
    '{16'd5120,  16'd19200, 32'hF0F0_F0F0, 1'b1, 1'b0, 0,   0},
    // Rows 0 and 240 lie on the border and are dropped.
    '{16'd5120,  16'd0,     32'h0000_0001, 1'b1, 1'b0, 0,   0},
    '{16'd5120,  16'd15360, 32'h8000_0000, 1'b1, 1'b0, 0,   0},
    // Full-range extremes of the offset fields.
    '{16'h7FFF,  16'h7FFF,  32'hDEAD_BEEF, 1'b1, 1'b0, 0,   0},
    '{16'h8000,  16'h8000,  32'hCAFE_F00D, 1'b1, 1'b0, 0,   0},
    // Column 240 on the centre row 120.
    '{16'd12800, 16'd7680,  32'h00FF_00FF, 1'b1, 1'b1, 240, 120},
    // Alternating bit patterns, checked by the predictor.
    '{16'h5555,  16'h2AAA,  32'h5555_5555, 1'b0, 1'b0, 0,   0},
    '{16'hAAAA,  16'h5555,  32'hAAAA_AAAA, 1'b0, 1'b0, 0,   0},
    '{16'h3C3C,  16'h1E1E,  32'h3C3C_C3C3, 1'b0, 1'b0, 0,   0}
  };

  // Configuration phases. The first few pin down the extremes, then the
  // zero and oversized stretch cases, raw out-of-range values, and finally
  // random settings.
  phase_t phases [0:NumPhases-1] = '{
    '{30719, 23039, 11585,  11585,  64,  100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
    '{0,     0,     -16384, 16384,  256, 100, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{12000, 9000,  0,      -16384, 128, 100, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0},
    '{15000, 11000, 16384,  0,      0,   40,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{0,     0,     16384,  0,      511, 100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32767, 32767, -32768, -32768, 300, 60,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{0,     0,     0,      0,      0,   100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{0,     0,     0,      0,      0,   100, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
    '{0,     0,     0,      0,      0,   100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  starfield_point_rotate_clip #(
    .FRAC_BITS      (FracBits),
    .TRIG_FRAC_BITS (TrigFracBits)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Maps one star to its screen pixel under configuration c. Returns 0 when
  // the star lands off the stretched screen. All sums are exact in 64 bits;
  // the division truncates toward zero and the pixel wraps to 16 bits.
  function automatic bit project_star(input cfg_t c, input logic [OffW-1:0] ox,
                                      input logic [OffW-1:0] oy,
                                      input logic [ColorW-1:0] color,
                                      output pixel_t pix);
    longint st, cs, sn, bx, by, ax, ay, q, vx, vy;
    st = longint'(c.x_stretch);
    cs = longint'($signed(c.cos_roll));
    sn = longint'($signed(c.sin_roll));
    bx = (longint'($signed(ox)) + longint'(c.field_x)) * st;
    if (bx >= longint'(WrapX) * st * OneF) bx -= longint'(SpanX) * st * OneF;
    bx -= longint'(CtrX) * st * OneF;
    by = longint'($signed(oy)) + longint'(c.field_y);
    if (by >= longint'(WrapY) * OneF) by -= longint'(SpanY) * OneF;
    by -= longint'(CtrY) * OneF;
    ax = cs * bx + sn * by * OneF + longint'(CtrX) * OneRot;
    ay = cs * by * OneF - sn * bx + longint'(CtrY) * OneRot;
    q  = ax / OneRot;
    vx = longint'($signed(q[PixW-1:0]));
    q  = ay / OneRot;
    vy = longint'($signed(q[PixW-1:0]));
    pix.px    = vx[PixXW-1:0];
    pix.py    = vy[PixYW-1:0];
    pix.color = color;
    return vx >= 0 && vx * OneF < longint'(ScrW) * st && vy > 0 && vy < longint'(ScrH);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MaxShown) $display("ERROR: %s", msg);
  endtask

  // Idle cycles before the next star: mostly none, sometimes a few, rarely
  // a long gap; tx_steady keeps the sender from idling.
  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (tx_steady || pick < 70) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offers one star and waits for its transfer. For a star due on screen, the
  // expected pixel is queued at the accepting edge, hand-written or predicted.
  task automatic send_star(input logic [OffW-1:0] ox, input logic [OffW-1:0] oy,
                           input logic [ColorW-1:0] color, input bit typed,
                           input bit typed_hit, input pixel_t typed_pix);
    int     gap;
    bit     hit;
    pixel_t pix;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {color, oy, ox};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) begin
      hit = typed_hit;
      pix = typed_pix;
    end else begin
      hit = project_star(shadow_cfg, ox, oy, color, pix);
    end
    if (hit) pending_pixels.push_back(pix);
  endtask

  // Stops offering stars and waits, within a bound, for every expected
  // pixel, then lets stars that end off screen leave the pipeline.
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      flag_error($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
      pending_pixels.delete();
    end
    repeat (LatencyPause) @(posedge clk);
  endtask

  // APB write, followed by a read of the same register when that register exists.
  // Register slots past the last one are unused and not read back; the write must
  // leave the others unchanged, and the star results after it show whether it did.
  task automatic write_reg(input int idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] want_rd;
    logic [DataW-1:0] mask;
    bit               known;
    known = 1'b1;
    case (idx)
      REG_FIELD_X: begin
        shadow_cfg.field_x = value[FieldW-1:0];
        want_rd = DataW'(shadow_cfg.field_x);
        mask    = (DataW'(1) << FieldW) - 1;
      end
      REG_FIELD_Y: begin
        shadow_cfg.field_y = value[FieldW-1:0];
        want_rd = DataW'(shadow_cfg.field_y);
        mask    = (DataW'(1) << FieldW) - 1;
      end
      REG_COS_ROLL: begin
        shadow_cfg.cos_roll = value[TrigW-1:0];
        want_rd = DataW'(value[TrigW-1:0]);
        mask    = (DataW'(1) << TrigW) - 1;
      end
      REG_SIN_ROLL: begin
        shadow_cfg.sin_roll = value[TrigW-1:0];
        want_rd = DataW'(value[TrigW-1:0]);
        mask    = (DataW'(1) << TrigW) - 1;
      end
      REG_X_STRETCH: begin
        shadow_cfg.x_stretch = value[StretchW-1:0];
        want_rd = DataW'(shadow_cfg.x_stretch);
        mask    = (DataW'(1) << StretchW) - 1;
      end
      default: begin
        known   = 1'b0;
        want_rd = '0;
        mask    = '0;
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (known) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if ((prdata & mask) !== want_rd)
        flag_error($sformatf("register %0d reads %h, expected %h", idx, prdata & mask,
                             want_rd));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink. It mostly accepts, stalls briefly now and then and
  // sometimes for long. On request it holds off for a long fixed stretch
  // so that the pipeline fills and pushes back on the star input.
  initial begin
    int pick;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (rx_steady || pick < 60) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (pick < 90) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  end

  // Every pixel transfer is compared with the oldest expected pixel.
  always @(posedge clk) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.px    = out_tdata[PixXW-1:0];
      got.py    = out_tdata[PixXW +: PixYW];
      got.color = out_tdata[PixXW+PixYW +: ColorW];
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel x=%0d y=%0d color=%h", got.px, got.py,
                             got.color));
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want)
          flag_error($sformatf("pixel expected x=%0d y=%0d color=%h, got x=%0d y=%0d color=%h",
                               want.px, want.py, want.color, got.px, got.py, got.color));
      end
    end
  end

  // Stimulus: reset, the directed table under the reset configuration,
  // then one phase of random stars per configuration setting.
  initial begin
    int     k;
    int     p;
    phase_t ph;
    pixel_t typed_pix;
    logic [OffW-1:0] ox;
    logic [OffW-1:0] oy;
    err_count  = 0;
    rx_steady  = 1'b0;
    tx_steady  = 1'b0;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    shadow_cfg = '{field_x: '0, field_y: '0, cos_roll: 16'sd16384, sin_roll: '0,
                   x_stretch: 9'd128};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NumRows; k++) begin
      typed_pix = '{px: PixXW'(star_rows[k].px), py: PixYW'(star_rows[k].py),
                    color: star_rows[k].color};
      send_star(star_rows[k].ox, star_rows[k].oy, star_rows[k].color, star_rows[k].typed,
                star_rows[k].hit, typed_pix);
    end
    wait_drained();

    for (p = 0; p < NumPhases; p++) begin
      ph = phases[p];
      if (ph.rnd) begin
        // Mostly nominal settings, with a chance of raw full-width values.
        ph.fx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 30719);
        ph.fy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 23039);
        ph.cs = int'($urandom_range(0, 32768)) - 16384;
        ph.sn = int'($urandom_range(0, 32768)) - 16384;
        ph.st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(64, 256);
      end
      write_reg(REG_FIELD_X, DataW'(ph.fx));
      write_reg(REG_FIELD_Y, DataW'(ph.fy));
      write_reg(REG_COS_ROLL, DataW'(ph.cs));
      write_reg(REG_SIN_ROLL, DataW'(ph.sn));
      write_reg(REG_X_STRETCH, DataW'(ph.st));
      write_reg($urandom_range(NumRegs, LastRegSlot), $urandom);
      @(posedge clk);

      rx_steady = ph.rx_steady;
      tx_steady = ph.tx_steady || ph.long_hold;
      if (ph.long_hold) hold_req = 1'b1;
      for (k = 0; k < ph.items; k++) begin
        // After the first stretch of a hold phase the sender idles again.
        if (ph.long_hold && k == ph.items / 2) tx_steady = 1'b0;
        if (ph.mid_pause && k == ph.items / 2) wait_drained();
        if ($urandom_range(0, 99) < 85) begin
          ox = OffW'($urandom_range(0, 30720) - 5120);
          oy = OffW'($urandom_range(0, 23040) - 3840);
        end else begin
          ox = OffW'($urandom);
          oy = OffW'($urandom);
        end
        send_star(ox, oy, $urandom, 1'b0, 1'b0, '0);
      end
      wait_drained();
      rx_steady = 1'b0;
      tx_steady = 1'b0;
    end

    repeat (LatencyPause) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
